@@ sv/strict_decimal_integer_parser_unit_defines.svh @@
`ifndef STRICT_DECIMAL_INTEGER_PARSER_UNIT_DEFINES_SVH
`define STRICT_DECIMAL_INTEGER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SDIP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define SDIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/sdip_pkg.sv @@
package sdip_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned DigitWidth = 4;
   // room for magnitude * 10 + digit
   localparam int unsigned ProdWidth  = ValueWidth + 4;

   localparam logic [ValueWidth-1:0] LimU64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [ValueWidth-1:0] LimNeg = 64'h8000_0000_0000_0000;
   localparam logic [ValueWidth-1:0] LimPos = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [CharWidth-1:0] ChNul   = 8'h00;
   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChNine  = 8'h39;
   localparam logic [CharWidth-1:0] ChPlus  = 8'h2B;
   localparam logic [CharWidth-1:0] ChMinus = 8'h2D;
   localparam logic [CharWidth-1:0] ChSpace = 8'h20;
   localparam logic [CharWidth-1:0] ChTab   = 8'h09;

   localparam logic CsrSignedMode    = 1'b0;
   localparam logic CsrUnsignedLimit = 1'b1;

   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_SIGN  = 5'b00010,
      PH_DIGIT = 5'b00100,
      PH_TRAIL = 5'b01000,
      PH_BAD   = 5'b10000
   } phase_type;

endpackage

@@ sv/sdip_if.sv @@
interface sdip_req_if import sdip_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface sdip_rsp_if import sdip_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] value;
   logic                  ok;

   modport source (output valid, output value, output ok, input ready);
   modport sink   (input valid, input value, input ok, output ready);
endinterface

@@ sv/strict_decimal_integer_parser_unit.sv @@
// Channel | Dir | Payload                  | Handshake
// req     | in  | char_code[7:0]           | valid/ready
// rsp     | out | value[63:0], ok          | valid/ready
// csr     | in  | index[0], write_data[63:0] | write_enable
//
// One character a cycle sustained, unless a NUL waits behind an untaken response.
// The character is registered, then one stage does multiply-by-ten, add and limit
// compare against the parse state and loads the response register on a NUL.
// Synchronous active-high reset returns the parse state to leading blanks.
// Only a NUL waiting behind an untaken response stalls the request side.
`include "strict_decimal_integer_parser_unit_defines.svh"

module strict_decimal_integer_parser_unit import sdip_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sdip_req_if.sink              req,
   sdip_rsp_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [ValueWidth-1:0] csr_write_data
);

   logic                  signed_mode_ff;
   logic [ValueWidth-1:0] unsigned_limit_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [CharWidth-1:0]  s1_char_ff;
   logic                  s1_term;
   logic                  s1_go;

   phase_type             phase_ff, phase_in;
   logic [ValueWidth-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_ok_ff, rsp_ok_in;

   logic                  is_blank, is_digit;
   logic [DigitWidth-1:0] digit;
   logic [ValueWidth-1:0] lim;
   logic [ProdWidth-1:0]  mag_ext, prod;
   logic                  fits;
   logic                  end_ok;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff    <= 1'b0;
         unsigned_limit_ff <= LimU64;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrSignedMode:    signed_mode_ff    <= csr_write_data[0];
            CsrUnsignedLimit: unsigned_limit_ff <= csr_write_data;
            default:          ;
         endcase
      end
   end

   // input stage
   assign s1_term   = (s1_char_ff == ChNul);
   assign s1_go     = s1_valid_ff && (!s1_term || !rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req.ready) s1_valid_in = req.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) s1_char_ff <= req.char_code;
   end

   // digit step: magnitude * 10 + digit must stay at or below the limit
   assign is_blank = (s1_char_ff == ChSpace) || (s1_char_ff == ChTab);
   assign is_digit = (s1_char_ff >= ChZero) && (s1_char_ff <= ChNine);
   assign digit    = DigitWidth'(s1_char_ff - ChZero);
   assign lim      = !signed_mode_ff ? LimU64 : (neg_ff ? LimNeg : LimPos);
   assign mag_ext  = {{(ProdWidth-ValueWidth){1'b0}}, mag_ff};
   assign prod     = (mag_ext << 3) + (mag_ext << 1)
                     + {{(ProdWidth-DigitWidth){1'b0}}, digit};
   assign fits     = (prod <= {{(ProdWidth-ValueWidth){1'b0}}, lim});

   always_comb begin
      phase_in = phase_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      if (s1_go) begin
         if (s1_term) begin
            phase_in = PH_LEAD;
            mag_in   = '0;
            neg_in   = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_LEAD: begin
                  if (is_blank) begin
                     phase_in = PH_LEAD;
                  end else if (s1_char_ff == ChPlus) begin
                     phase_in = PH_SIGN;
                  end else if (s1_char_ff == ChMinus && signed_mode_ff) begin
                     phase_in = PH_SIGN;
                     neg_in   = 1'b1;
                  end else if (is_digit && fits) begin
                     phase_in = PH_DIGIT;
                     mag_in   = prod[ValueWidth-1:0];
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_SIGN: begin
                  if (is_digit && fits) begin
                     phase_in = PH_DIGIT;
                     mag_in   = prod[ValueWidth-1:0];
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_DIGIT: begin
                  if (is_digit && fits) mag_in = prod[ValueWidth-1:0];
                  else if (is_blank)    phase_in = PH_TRAIL;
                  else                  phase_in = PH_BAD;
               end
               PH_TRAIL: begin
                  if (!is_blank) phase_in = PH_BAD;
               end
               default: phase_in = PH_BAD;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
      end
   end

   // response register, re-checked under the current mode at the NUL
   assign end_ok = ((phase_ff == PH_DIGIT) || (phase_ff == PH_TRAIL))
                   && (signed_mode_ff ? (mag_ff <= lim)
                                      : (!neg_ff && mag_ff <= unsigned_limit_ff));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (s1_go && s1_term) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = end_ok;
         if (!end_ok)     rsp_value_in = '0;
         else if (neg_ff) rsp_value_in = ~mag_ff + ValueWidth'(1);
         else             rsp_value_in = mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.value = rsp_value_ff;
   assign rsp.ok    = rsp_ok_ff;

   `SDIP_ASSERT_NOW(a_phase_onehot, clock, reset, 1'b1, $onehot(phase_ff),
      "parse phase not one-hot")
   `SDIP_ASSERT_NEXT(a_nul_clears_state, clock, reset, s1_go && s1_term,
      phase_ff == PH_LEAD && mag_ff == '0 && !neg_ff,
      "parse state not cleared after NUL")
   `SDIP_ASSERT_NOW(a_stall_only_on_nul, clock, reset, !req.ready,
      s1_valid_ff && s1_term && rsp_valid_ff,
      "request side stalled without a pending NUL")
   `SDIP_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff,
      rsp_value_ff == '0, "rejected response carries a non-zero value")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench import sdip_pkg::*; ();

   localparam int ClockHalf    = 5;
   localparam int ResetCycles  = 11;
   localparam int SettleCycles = 4;
   localparam int LongHold     = 300;
   localparam int PhaseChars   = 116;
   localparam int RandomPhases = 8;
   localparam int CycleLimit   = 200000;
   localparam int NumRows      = 26;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  ok;
   } parse_result_type;

   // typed-in answer travelling with a terminator, used instead of the prediction
   typedef struct packed {
      logic             known;
      parse_result_type res;
   } answer_note_type;

   typedef struct {
      logic                  mode;
      logic [ValueWidth-1:0] limit;
      string                 text;
      int                    cut;
      logic                  mode_after;
      logic                  known;
      logic [ValueWidth-1:0] value;
      logic                  ok;
   } directed_row_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_PERIODIC
   } stall_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_enable;
   logic                  csr_index;
   logic [ValueWidth-1:0] csr_write_data;

   sdip_req_if req ();
   sdip_rsp_if rsp ();

   strict_decimal_integer_parser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #ClockHalf clock = ~clock;

   // parser image kept alongside the block
   logic                  mode_signed;
   logic [ValueWidth-1:0] limit_unsigned;
   phase_type             parse_phase;
   logic [ValueWidth-1:0] parse_mag;
   logic                  parse_neg;

   parse_result_type awaited_numbers[$];
   answer_note_type  answer_notes[$];
   logic [CharWidth-1:0] backlog[$];

   int unsigned failures      = 0;
   int unsigned checked_count = 0;
   int unsigned chars_sent    = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_done    = 0;
   int unsigned cycle_count   = 0;
   int          burst_left    = 0;
   logic                  cfg_signed;
   logic [ValueWidth-1:0] cfg_limit;

   directed_row_type directed_rows [NumRows] = '{
      '{1'b0, LimU64, "", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, LimU64, "0", 0, 1'b0, 1'b1, 64'd0, 1'b1},
      '{1'b0, LimU64, "18446744073709551615", 0, 1'b0, 1'b1, LimU64, 1'b1},
      '{1'b0, LimU64, "18446744073709551616", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, LimU64, " \t+42\t ", 0, 1'b0, 1'b0, 64'd0, 1'b0},
      '{1'b0, LimU64, "-1", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, LimU64, "+", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, LimU64, " \t \t", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, LimU64, "12 3", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, LimU64, "7a99", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, LimU64, "\377", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, LimU64, "++5", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, 64'd1000, "1000", 0, 1'b0, 1'b1, 64'd1000, 1'b1},
      '{1'b0, 64'd1000, "1001", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, 64'd0, "000", 0, 1'b0, 1'b1, 64'd0, 1'b1},
      '{1'b0, 64'd0, "1", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      // unsigned maximum, switched to signed before the last digit
      '{1'b0, LimU64, "18446744073709551615", 19, 1'b1, 1'b1, 64'd0, 1'b0},
      '{1'b1, LimU64, "9223372036854775807", 0, 1'b0, 1'b1, LimPos, 1'b1},
      '{1'b1, LimU64, "9223372036854775808", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b1, LimU64, "-9223372036854775808", 0, 1'b0, 1'b1, LimNeg, 1'b1},
      '{1'b1, LimU64, "-9223372036854775809", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b1, LimU64, "-0", 0, 1'b0, 1'b1, 64'd0, 1'b1},
      '{1'b1, LimU64, "\t-17 ", 0, 1'b0, 1'b0, 64'd0, 1'b0},
      '{1'b1, LimU64, "-+1", 0, 1'b0, 1'b1, 64'd0, 1'b0},
      // negative sign left over when unsigned mode returns
      '{1'b1, LimU64, "-5", 2, 1'b0, 1'b1, 64'd0, 1'b0},
      '{1'b0, 64'd50, "77", 1, 1'b1, 1'b0, 64'd0, 1'b0}
   };

   task automatic parse_char(input logic [CharWidth-1:0] c);
      logic [ValueWidth-1:0] ceiling;
      logic [ValueWidth-1:0] digit;
      logic                  blank;
      logic                  numeral;
      logic                  fits;
      logic                  good;
      parse_result_type      res;
      answer_note_type       note;
      blank   = (c == ChSpace) || (c == ChTab);
      numeral = (c >= ChZero) && (c <= ChNine);
      digit   = ValueWidth'(c) - ValueWidth'(ChZero);
      ceiling = !mode_signed ? LimU64 : (parse_neg ? LimNeg : LimPos);
      fits    = parse_mag <= (ceiling - digit) / 10;
      if (c == ChNul) begin
         good      = (parse_phase == PH_DIGIT) || (parse_phase == PH_TRAIL);
         res.value = '0;
         if (good && mode_signed) begin
            good      = parse_mag <= ceiling;
            res.value = parse_neg ? -parse_mag : parse_mag;
         end else if (good) begin
            good      = !parse_neg && (parse_mag <= limit_unsigned);
            res.value = parse_mag;
         end
         if (!good) res.value = '0;
         res.ok = good;
         note = (answer_notes.size() != 0) ? answer_notes.pop_front() : '0;
         awaited_numbers.push_back(note.known ? note.res : res);
         parse_phase = PH_LEAD;
         parse_mag   = '0;
         parse_neg   = 1'b0;
      end else begin
         case (parse_phase)
            PH_LEAD: begin
               if (c == ChPlus) begin
                  parse_phase = PH_SIGN;
               end else if (c == ChMinus && mode_signed) begin
                  parse_neg   = 1'b1;
                  parse_phase = PH_SIGN;
               end else if (numeral && fits) begin
                  parse_mag   = parse_mag * 10 + digit;
                  parse_phase = PH_DIGIT;
               end else if (!blank) begin
                  parse_phase = PH_BAD;
               end
            end
            PH_SIGN: begin
               if (numeral && fits) begin
                  parse_mag   = parse_mag * 10 + digit;
                  parse_phase = PH_DIGIT;
               end else begin
                  parse_phase = PH_BAD;
               end
            end
            PH_DIGIT: begin
               if (numeral && fits) parse_mag = parse_mag * 10 + digit;
               else if (blank) parse_phase = PH_TRAIL;
               else parse_phase = PH_BAD;
            end
            PH_TRAIL: begin
               if (!blank) parse_phase = PH_BAD;
            end
            default: parse_phase = PH_BAD;
         endcase
      end
   endtask

   // responses checked first, then register writes, then the accepted request
   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         mode_signed    = 1'b0;
         limit_unsigned = LimU64;
         parse_phase    = PH_LEAD;
         parse_mag      = '0;
         parse_neg      = 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (awaited_numbers.size() == 0) begin
               $error("response with none awaited: value %h ok %b", rsp.value, rsp.ok);
               failures++;
            end else begin
               want = awaited_numbers.pop_front();
               if (rsp.value !== want.value) begin
                  $error("value: expected %h, got %h", want.value, rsp.value);
                  failures++;
               end
               if (rsp.ok !== want.ok) begin
                  $error("ok: expected %b, got %b", want.ok, rsp.ok);
                  failures++;
               end
               checked_count++;
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CsrSignedMode) mode_signed = csr_write_data[0];
            else if (csr_index == CsrUnsignedLimit) limit_unsigned = csr_write_data;
         end
         if (req.valid && req.ready) parse_char(req.char_code);
      end
   end

   // receiver: changing stall patterns, plus a long hold-off on demand
   initial begin
      stall_pattern_type style;
      int                style_left;
      style      = READY_ALWAYS;
      style_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end
         if (style_left == 0) begin
            style      = stall_pattern_type'($urandom_range(0, 3));
            style_left = $urandom_range(16, 128);
         end
         style_left--;
         case (style)
            READY_ALWAYS: rsp.ready <= 1'b1;
            READY_COIN:   rsp.ready <= ($urandom_range(0, 1) == 1);
            READY_MOSTLY: rsp.ready <= ($urandom_range(0, 7) != 0);
            default:      rsp.ready <= (style_left % 4 == 0);
         endcase
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
   end

   task automatic offer(input logic [CharWidth-1:0] c, input logic known,
                        input parse_result_type res);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      if (c == ChNul) answer_notes.push_back(answer_note_type'{known, res});
      req.valid     <= 1'b1;
      req.char_code <= c;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      chars_sent++;
   endtask

   // sender stops, every awaited response arrives, pipeline drains
   task automatic settle();
      req.valid <= 1'b0;
      do @(posedge clock); while (awaited_numbers.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic reconfigure(input logic mode, input logic [ValueWidth-1:0] limit);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CsrSignedMode;
      csr_write_data   <= ValueWidth'(mode);
      @(posedge clock);
      csr_index        <= CsrUnsignedLimit;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_signed = mode;
      cfg_limit  = limit;
   endtask

   task automatic push_decimal(input logic [67:0] n);
      logic [CharWidth-1:0] digits[$];
      do begin
         digits.push_front(ChZero + CharWidth'(n % 10));
         n = n / 10;
      end while (n != 0);
      foreach (digits[k]) backlog.push_back(digits[k]);
   endtask

   initial begin
      int                    len;
      int                    sent;
      int                    kind;
      logic                  mode;
      logic [ValueWidth-1:0] limit;
      logic [67:0]           mag;
      req.valid        <= 1'b0;
      req.char_code    <= ChNul;
      csr_write_enable <= 1'b0;
      csr_index        <= CsrSignedMode;
      csr_write_data   <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      reconfigure(1'b0, LimU64);
      foreach (directed_rows[r]) begin
         if (directed_rows[r].mode != cfg_signed || directed_rows[r].limit != cfg_limit)
            reconfigure(directed_rows[r].mode, directed_rows[r].limit);
         len = directed_rows[r].text.len();
         for (int i = 0; i <= len; i++) begin
            if (directed_rows[r].cut != 0 && i == directed_rows[r].cut)
               reconfigure(directed_rows[r].mode_after, cfg_limit);
            if (i == len)
               offer(ChNul, directed_rows[r].known,
                     parse_result_type'{directed_rows[r].value, directed_rows[r].ok});
            else
               offer(directed_rows[r].text[i], 1'b0, '0);
         end
      end

      // leftover characters carry over a phase change, so some land mid-string
      for (int p = 0; p < RandomPhases; p++) begin
         case (p)
            0: begin mode = 1'b0; limit = LimU64; end
            1: begin mode = 1'b1; limit = '0; end
            2: begin mode = 1'b0; limit = '0; end
            3: begin mode = 1'b0; limit = {$urandom, $urandom} >> $urandom_range(0, 63); end
            default: begin
               mode  = 1'($urandom_range(0, 1));
               limit = $urandom_range(0, 1) ? LimU64
                                            : {$urandom, $urandom} >> $urandom_range(0, 63);
            end
         endcase
         reconfigure(mode, limit);
         if (p == 1) hold_requests++;
         sent = 0;
         while (sent < PhaseChars) begin
            if (backlog.size() == 0) begin
               kind = $urandom_range(0, 9);
               repeat ($urandom_range(0, 2))
                  backlog.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
               if (kind <= 6) begin
                  case ($urandom_range(0, 3))
                     0: backlog.push_back(ChPlus);
                     1: if (cfg_signed || $urandom_range(0, 7) == 0) backlog.push_back(ChMinus);
                     default: ;
                  endcase
                  if ($urandom_range(0, 7) == 0)
                     repeat ($urandom_range(1, 3)) backlog.push_back(ChZero);
                  case ($urandom_range(0, 3))
                     0, 1: mag = 68'($urandom_range(0, 999));
                     2: begin
                        case ($urandom_range(0, 3))
                           0: mag = 68'(LimU64);
                           1: mag = 68'(LimPos);
                           2: mag = 68'(LimNeg);
                           default: mag = 68'(cfg_limit);
                        endcase
                        mag = mag + 68'($urandom_range(0, 6));
                        mag = (mag >= 3) ? mag - 3 : mag;
                     end
                     default: mag = 68'({$urandom, $urandom} >> $urandom_range(0, 63));
                  endcase
                  push_decimal(mag);
                  repeat ($urandom_range(0, 2))
                     backlog.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
               end else if (kind <= 8) begin
                  push_decimal(68'($urandom_range(0, 99)));
                  backlog.push_back(CharWidth'($urandom_range(1, 255)));
                  if ($urandom_range(0, 1)) push_decimal(68'($urandom_range(0, 99)));
               end else begin
                  repeat ($urandom_range(0, 6))
                     backlog.push_back(CharWidth'($urandom_range(1, 255)));
               end
               // now and then the terminator is dropped and strings run together
               if ($urandom_range(0, 15) != 0) backlog.push_back(ChNul);
            end
            offer(backlog.pop_front(), 1'b0, '0);
            sent++;
         end
      end

      settle();
      $display("Run: %0d characters sent, %0d parse results checked", chars_sent,
               checked_count);
      $display("Run: directed edge cases, %0d random register settings, one long stall",
               RandomPhases);
      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
